FILE: rtl/assert_macros.svh
// Assertion macros shared by the root block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that must be followed by another in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/ikr_pkg.sv
// Shared constants and controller/datapath interface types for the k-th root block.
package ikr_pkg;

  localparam int WORD_BITS_DEF = 64;
  localparam int VALUE_BITS    = 64;
  localparam int DEGREE_BITS   = 7;
  // Width of the candidate digit multiplied into the trial power per cycle.
  localparam int DIGIT_BITS    = 16;

  typedef struct packed {
    logic load;    // capture a new radicand and degree
    logic trial;   // set up or resolve the trial of the current candidate bit
    logic mul;     // one digit step of the trial power multiply
    logic finish;  // write the result registers
  } cmd_t;

  typedef struct packed {
    logic special;   // zero input, degree one, or degree above the log of the radicand
    logic quick;     // candidate resolves without multiplying
    logic mul_end;   // the multiply step ends the trial of this bit
    logic last_bit;  // current candidate bit is bit zero
  } status_t;

endpackage

FILE: rtl/ikr_ctrl.sv
// Sequencing state machine for the k-th root block.
`include "assert_macros.svh"

module ikr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ikr_pkg::status_t st,
  output ikr_pkg::cmd_t   cmd
);
  import ikr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_TRIAL,
    S_MUL,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        state_nxt = st.special ? S_FIN : S_TRIAL;
      end
      S_TRIAL: begin
        cmd.trial = 1'b1;
        if (st.quick) begin
          if (st.last_bit) state_nxt = S_FIN;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (st.mul_end) state_nxt = st.last_bit ? S_FIN : S_TRIAL;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `ASSERT_HOLDS(a_fin_slot, cmd.finish |-> (!out_valid_r || out_ready), "result written over a pending beat")
  `ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while one is in work")
  `ASSERT_NEXT(a_fin_shows, cmd.finish, out_valid_r, "finished result not presented")

endmodule

FILE: rtl/ikr_dpath.sv
// Datapath of the k-th root block: bit-by-bit root search with a digit-serial power unit.
`include "assert_macros.svh"

module ikr_dpath #(
  parameter int WORD_BITS = ikr_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ikr_pkg::cmd_t                   cmd,
  output ikr_pkg::status_t                st,
  input  logic [ikr_pkg::VALUE_BITS-1:0]  in_value,
  input  logic [ikr_pkg::DEGREE_BITS-1:0] in_degree,
  output logic [ikr_pkg::VALUE_BITS-1:0]  root_result,
  output logic [ikr_pkg::VALUE_BITS-1:0]  remainder_out,
  output logic                            input_valid
);
  import ikr_pkg::*;

  localparam int W     = WORD_BITS;
  // For degree two and up the root fits in half the word's bit count, rounded up.
  localparam int HALF  = (W + 1) / 2;
  localparam int BW    = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int NDIG  = (HALF + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int CW    = NDIG * DIGIT_BITS;
  localparam int DGW   = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int PW    = W + DIGIT_BITS + 1;
  localparam int START = HALF - 1;

  logic [W-1:0]           n_r, n_nxt;
  logic [DEGREE_BITS-1:0] k_r, k_nxt;
  logic [HALF-1:0]        r_r, r_nxt;
  logic [W-1:0]           pow_r, pow_nxt;
  logic [BW-1:0]          bit_r, bit_nxt;
  logic [W-1:0]           p_r, p_nxt;
  logic [W-1:0]           acc_r, acc_nxt;
  logic [DGW-1:0]         dig_r, dig_nxt;
  logic [DEGREE_BITS-1:0] mcnt_r, mcnt_nxt;
  logic [W-1:0]           root_r, root_nxt;
  logic [W-1:0]           rem_r, rem_nxt;
  logic                   ivld_r, ivld_nxt;

  logic [HALF-1:0]       cand;
  logic [W-1:0]          cand_w;
  logic [CW-1:0]         cand_pad;
  logic [DIGIT_BITS-1:0] digit;
  logic [PW-1:0]         prod;
  logic [PW-1:0]         step_sum;
  logic                  over;
  logic                  pow_done;
  logic                  zero_in;
  logic                  one_deg;
  logic                  big_deg;

  assign cand     = r_r | (HALF'(1) << bit_r);
  assign cand_w   = W'(cand);
  assign cand_pad = CW'(cand);
  assign digit    = cand_pad[dig_r * DIGIT_BITS +: DIGIT_BITS];

  // Product so far times one candidate digit, most significant digit first.
  assign prod     = PW'(p_r) * PW'(digit);
  assign step_sum = (PW'(acc_r) << DIGIT_BITS) + prod;
  // Once the partial sum passes the radicand, later digits only make it larger.
  assign over     = step_sum > PW'(n_r);
  assign pow_done = (dig_r == '0) && (mcnt_r == k_r - DEGREE_BITS'(1));

  assign zero_in  = (n_r == '0) || (k_r == '0);
  assign one_deg  = (k_r == DEGREE_BITS'(1));
  assign big_deg  = ((n_r >> k_r) == '0);

  assign st.special  = zero_in || one_deg || big_deg;
  assign st.quick    = (cand_w > n_r) || (cand == HALF'(1));
  assign st.mul_end  = over || pow_done;
  assign st.last_bit = (bit_r == '0);

  always_comb begin
    n_nxt    = n_r;
    k_nxt    = k_r;
    r_nxt    = r_r;
    pow_nxt  = pow_r;
    bit_nxt  = bit_r;
    p_nxt    = p_r;
    acc_nxt  = acc_r;
    dig_nxt  = dig_r;
    mcnt_nxt = mcnt_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    ivld_nxt = ivld_r;

    if (cmd.load) begin
      n_nxt   = in_value[W-1:0];
      k_nxt   = in_degree;
      r_nxt   = '0;
      pow_nxt = '0;
      bit_nxt = BW'(START);
    end

    if (cmd.trial) begin
      if (st.quick) begin
        // A candidate of one always fits; one above the radicand never does.
        if (cand == HALF'(1)) begin
          r_nxt   = cand;
          pow_nxt = W'(1);
        end
        if (!st.last_bit) bit_nxt = bit_r - BW'(1);
      end else begin
        p_nxt    = cand_w;
        acc_nxt  = '0;
        dig_nxt  = DGW'(NDIG - 1);
        mcnt_nxt = DEGREE_BITS'(1);
      end
    end

    if (cmd.mul) begin
      if (over) begin
        if (!st.last_bit) bit_nxt = bit_r - BW'(1);
      end else if (dig_r == '0) begin
        if (pow_done) begin
          r_nxt   = cand;
          pow_nxt = step_sum[W-1:0];
          if (!st.last_bit) bit_nxt = bit_r - BW'(1);
        end else begin
          p_nxt    = step_sum[W-1:0];
          acc_nxt  = '0;
          dig_nxt  = DGW'(NDIG - 1);
          mcnt_nxt = mcnt_r + DEGREE_BITS'(1);
        end
      end else begin
        acc_nxt = step_sum[W-1:0];
        dig_nxt = dig_r - DGW'(1);
      end
    end

    if (cmd.finish) begin
      if (zero_in) begin
        root_nxt = '0;
        rem_nxt  = '0;
        ivld_nxt = 1'b0;
      end else if (one_deg) begin
        root_nxt = n_r;
        rem_nxt  = '0;
        ivld_nxt = 1'b1;
      end else if (big_deg) begin
        root_nxt = W'(1);
        rem_nxt  = n_r - W'(1);
        ivld_nxt = 1'b1;
      end else begin
        root_nxt = W'(r_r);
        rem_nxt  = n_r - pow_r;
        ivld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    r_r    <= r_nxt;
    pow_r  <= pow_nxt;
    bit_r  <= bit_nxt;
    p_r    <= p_nxt;
    acc_r  <= acc_nxt;
    dig_r  <= dig_nxt;
    mcnt_r <= mcnt_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    ivld_r <= ivld_nxt;
  end

  assign root_result   = VALUE_BITS'(root_r);
  assign remainder_out = VALUE_BITS'(rem_r);
  assign input_valid   = ivld_r;

  `ASSERT_HOLDS(a_acc_bound, cmd.mul |-> (acc_r <= n_r), "partial power above radicand")
  `ASSERT_HOLDS(a_mcnt_range, cmd.mul |-> ((mcnt_r != '0) && (mcnt_r < k_r)), "power count out of range")
  `ASSERT_HOLDS(a_pow_bound, (cmd.finish && !st.special) |-> (pow_r <= n_r), "root power above radicand")

endmodule

FILE: rtl/integer_kth_root_remainder.sv
// Top level of the integer k-th root with remainder block.
//
// Usage: one input beat carries a radicand (in_value, low WORD_BITS bits used) and a
// degree (in_degree). One output beat returns the floor of the degree-th root, the
// remainder value minus root to the degree, and a flag that is low when the value or
// the degree is zero (root and remainder are then zero). Both channels use valid and
// ready. The block works on one item at a time: in_ready is high only while the
// sequencer is idle, but that idle state is reached as soon as a result has been
// written into the output register, so the next beat can be taken in the cycle after
// that write, while the previous result still waits for out_ready.
// Sequence: zero value, zero degree, degree one, and degrees above the base-two log
// of the value go from the setup step straight to the finish step. Otherwise the
// root is searched one bit at a time over the lower half of the word's bits (32 bits
// at 64): each bit gets a trial step, followed by the digit steps of the trial power
// multiply unless the candidate resolves without one, and the trial stops as soon as
// the running product passes the radicand. The shared digit multiplier sets the pace,
// and the sequencer passes through its idle state between items.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
// When the receiver stalls, the finished result holds in the output register and a
// further item waits in the last sequencing step until the register frees up.

module integer_kth_root_remainder #(
  parameter int WORD_BITS = ikr_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ikr_pkg::VALUE_BITS-1:0]  in_value,
  input  logic [ikr_pkg::DEGREE_BITS-1:0] in_degree,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ikr_pkg::VALUE_BITS-1:0]  out_root_result,
  output logic [ikr_pkg::VALUE_BITS-1:0]  out_remainder_out,
  output logic                            out_input_valid
);
  import ikr_pkg::*;

  // Commands flow from the sequencer to the datapath; status flows back.
  cmd_t    cmd;
  status_t st;

  // The sequencer owns the handshakes and the output valid flag.
  ikr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the operands, the root search and the output payload.
  ikr_dpath #(
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_value      (in_value),
    .in_degree     (in_degree),
    .root_result   (out_root_result),
    .remainder_out (out_remainder_out),
    .input_valid   (out_input_valid)
  );

endmodule
